// ----- rtl/ncc_pkg.sv -----
`default_nettype none

package ncc_pkg;

    // Sentence phase, one-hot
    typedef enum logic [3:0] {
        PH_DONE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_MATCH    = 2'd0,
        VERDICT_MISMATCH = 2'd1,
        VERDICT_NO_STAR  = 2'd2
    } verdict_t;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned VERDICT_W     = 2;
    localparam int unsigned OUT_TDATA_W   = 16;
    localparam logic [BYTE_W-1:0] STAR_CODE           = 8'h2A;
    localparam logic [BYTE_W-1:0] MAX_BODY_LENGTH_RST = 8'd90;

    localparam logic [BYTE_W-1:0] CHAR_0     = 8'd48;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'd57;
    localparam logic [BYTE_W-1:0] CHAR_UP_A  = 8'd65;
    localparam logic [BYTE_W-1:0] CHAR_UP_F  = 8'd70;
    localparam logic [BYTE_W-1:0] CHAR_LO_A  = 8'd97;
    localparam logic [BYTE_W-1:0] CHAR_LO_F  = 8'd102;
    localparam logic [BYTE_W-1:0] UP_OFFSET  = 8'd55;
    localparam logic [BYTE_W-1:0] LO_OFFSET  = 8'd87;

    // Hex character to value; anything that is not a hex digit keeps its code
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        begin
            if (c >= CHAR_0 && c <= CHAR_9)
            begin
                v = c - CHAR_0;
            end
            else if (c >= CHAR_UP_A && c <= CHAR_UP_F)
            begin
                v = c - UP_OFFSET;
            end
            else if (c >= CHAR_LO_A && c <= CHAR_LO_F)
            begin
                v = c - LO_OFFSET;
            end
            else
            begin
                v = c;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/nmea_checksum_checker_top.sv -----
`default_nettype none

// NMEA 0183 sentence checksum checker.
// Input stream (s_*): one character per transaction, the sentence without its
// leading dollar sign. s_tuser set on a character starts a new sentence and
// abandons any sentence in progress without a verdict. Characters that arrive
// outside a sentence are dropped silently.
// Output stream (m_*): at most one transaction per sentence, carrying the
// verdict (match, mismatch, no asterisk within the limit) and the body length
// (nonzero only on a match). The verdict is issued on the second hex digit
// after the asterisk, or on the body byte that hits the length limit.
// Configuration: cfg_we writes cfg_wdata into max_body_length; write it only
// while no character or verdict is in flight.
// Timing: one character per cycle sustained while m_tready is high. A character
// sits in the input register after the accepting edge; the checksum/count update
// and verdict then move into the output register once it is free, so a verdict
// reaches m_tvalid through the input register and then the output register.
// Reset: the limit returns to 90 and the checker waits for a sentence start.
// Stall: while m_tready is low and a verdict is held, the input register still
// takes one character; further characters back up through s_tready.
module nmea_checksum_checker_top
    import ncc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [BYTE_W-1:0]      cfg_wdata,     // max_body_length
    // character stream in
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [BYTE_W-1:0]      s_tdata,       // [7:0] data_byte
    input  wire logic                   s_tuser,       // [0] sentence_start
    // verdict stream out
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata        // [1:0] verdict, [9:2] body_length
);

    logic [BYTE_W-1:0]  max_len_reg;

    // input register
    logic               in_valid_reg;
    logic [BYTE_W-1:0]  in_data_reg;
    logic               in_start_reg;

    // sentence state
    phase_t             phase_reg, phase_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic [BYTE_W-1:0]  count_reg, count_next;
    logic [3:0]         high_reg, high_next;

    // result register
    logic               out_valid_reg;
    verdict_t           verdict_reg, verdict_next;
    logic [BYTE_W-1:0]  len_reg, len_next;

    logic               advance;
    logic               emit;

    // working copies with a sentence start applied
    phase_t             ph;
    logic [BYTE_W-1:0]  xr;
    logic [BYTE_W-1:0]  cnt;
    logic [3:0]         hi;
    logic [BYTE_W-1:0]  cnt_inc;
    logic [BYTE_W-1:0]  low_val;
    logic [BYTE_W-1:0]  sum_val;

    // Move the held character into the result stage when that stage is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - BYTE_W - VERDICT_W){1'b0}}, len_reg, verdict_reg};

    always_comb
    begin
        ph      = in_start_reg ? PH_BODY : phase_reg;
        xr      = in_start_reg ? '0 : xor_reg;
        cnt     = in_start_reg ? '0 : count_reg;
        hi      = in_start_reg ? '0 : high_reg;
        cnt_inc = cnt + 8'd1;
        low_val = hex_digit(in_data_reg);
        sum_val = {hi, 4'b0000} + low_val;

        phase_next   = ph;
        xor_next     = xr;
        count_next   = cnt;
        high_next    = hi;
        emit         = 1'b0;
        verdict_next = VERDICT_NO_STAR;
        len_next     = '0;

        unique case (ph)
            PH_BODY:
            begin
                if (cnt >= max_len_reg)
                begin
                    emit = 1'b1;
                end
                else if (in_data_reg == STAR_CODE)
                begin
                    phase_next = PH_HIGH;
                end
                else
                begin
                    xor_next   = xr ^ in_data_reg;
                    count_next = cnt_inc;
                    // limit reached on this byte: fail at once
                    if (cnt_inc >= max_len_reg)
                    begin
                        emit = 1'b1;
                    end
                end
            end
            PH_HIGH:
            begin
                high_next  = low_val[3:0];
                phase_next = PH_LOW;
            end
            PH_LOW:
            begin
                emit = 1'b1;
                if (sum_val == xr)
                begin
                    verdict_next = VERDICT_MATCH;
                    len_next     = cnt;
                end
                else
                begin
                    verdict_next = VERDICT_MISMATCH;
                end
            end
            PH_DONE:
            begin
                // drop characters outside a sentence
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        if (emit)
        begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_BODY_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            max_len_reg <= cfg_wdata;
        end
    end

    // input register: hold until advanced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // sentence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            xor_reg   <= '0;
            count_reg <= '0;
            high_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            count_reg <= count_next;
            high_reg  <= high_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            verdict_reg <= verdict_next;
            len_reg     <= len_next;
        end
    end

    // a new verdict only ever comes from a character leaving the input register
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("verdict appeared without an advancing character");

    // a verdict always closes the sentence
    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> phase_reg == PH_DONE)
        else $error("sentence still open after a verdict");

    // body length is reported only with a match
    a_len_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && verdict_reg != VERDICT_MATCH |-> len_reg == '0)
        else $error("nonzero body length on a failed sentence");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (verdict_reg == VERDICT_MATCH || verdict_reg == VERDICT_MISMATCH
                      || verdict_reg == VERDICT_NO_STAR))
        else $error("undefined verdict code");

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

endmodule

`default_nettype wire
